// ===== design/ethernet_frame_rx_checker_defines.svh =====
// Assertion macros shared by the Ethernet frame receive checker.
`ifndef ETHERNET_FRAME_RX_CHECKER_DEFINES_SVH
`define ETHERNET_FRAME_RX_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define EFRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define EFRC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/efrc_pkg.sv =====
// Types, constants and the byte-wide CRC function of the frame receive checker.
package efrc_pkg;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [47:0] STATION_RESET = 48'h3DE12D6FE934;
    localparam logic [10:0] MIN_FRAME     = 11'd18;
    localparam logic [10:0] LEN_MAX       = 11'd2047;
    localparam logic [10:0] FCS_BYTES     = 11'd4;
    localparam logic [10:0] DA_END        = 11'd6;
    localparam logic [10:0] SA_END        = 11'd12;
    localparam logic [10:0] TYPE_END      = 11'd14;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic [15:0] ether_type;
        logic [47:0] source_address;
        logic [10:0] frame_length;
        logic        too_short;
        logic        dest_match;
        logic        fcs_ok;
    } t_report;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== design/efrc_parser.sv =====
// Per-frame state of the checker: CRC, byte count, address compare and captures.
module efrc_parser
    import efrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_item       i_item,
    input  logic [47:0] i_station,
    output t_report     o_report
);

    logic [31:0] r_crc;
    logic [10:0] r_count;
    logic [31:0] r_tail;
    logic        r_dest;
    logic [47:0] r_src;
    logic [15:0] r_type;

    logic [31:0] n_crc;
    logic [10:0] n_count;
    logic [31:0] n_tail;
    logic        n_dest;
    logic [47:0] n_src;
    logic [15:0] n_type;
    logic [7:0]  want;
    logic [31:0] fcs;
    logic        short_frame;

    always_comb begin
        case (r_count[2:0])
            3'd0:    want = i_station[47:40];
            3'd1:    want = i_station[39:32];
            3'd2:    want = i_station[31:24];
            3'd3:    want = i_station[23:16];
            3'd4:    want = i_station[15:8];
            3'd5:    want = i_station[7:0];
            default: want = 8'h00;
        endcase

        n_crc  = (r_count >= FCS_BYTES) ? crc_byte(r_crc, r_tail[31:24]) : r_crc;
        n_tail = {r_tail[23:0], i_item.frame_byte};
        n_dest = r_dest;
        n_src  = r_src;
        n_type = r_type;
        if (r_count < DA_END) begin
            if (want != i_item.frame_byte) begin
                n_dest = 1'b0;
            end
        end else if (r_count < SA_END) begin
            n_src = {r_src[39:0], i_item.frame_byte};
        end else if (r_count < TYPE_END) begin
            n_type = {r_type[7:0], i_item.frame_byte};
        end
        n_count = (r_count < LEN_MAX) ? r_count + 11'd1 : LEN_MAX;

        fcs         = {n_tail[7:0], n_tail[15:8], n_tail[23:16], n_tail[31:24]};
        short_frame = n_count < MIN_FRAME;

        o_report.fcs_ok         = !short_frame && (~n_crc == fcs);
        o_report.dest_match     = !short_frame && n_dest;
        o_report.too_short      = short_frame;
        o_report.frame_length   = n_count;
        o_report.source_address = short_frame ? 48'd0 : n_src;
        o_report.ether_type     = short_frame ? 16'd0 : n_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_byte)) begin
            r_crc   <= CRC_INIT;
            r_count <= 11'd0;
            r_tail  <= 32'd0;
            r_dest  <= 1'b1;
            r_src   <= 48'd0;
            r_type  <= 16'd0;
        end else if (i_fire) begin
            r_crc   <= n_crc;
            r_count <= n_count;
            r_tail  <= n_tail;
            r_dest  <= n_dest;
            r_src   <= n_src;
            r_type  <= n_type;
        end
    end

endmodule

// ===== design/ethernet_frame_rx_checker.sv =====
// Top level of the Ethernet frame receive checker with FCS and destination check.
// A report is registered in the output stage when the final byte leaves the input register.
// Throughput: one byte per cycle, set by the byte-wide CRC update between the
// input register and the report register; back-pressure stalls both stages.
// Reset clears all frame state and loads the default station address.
`include "ethernet_frame_rx_checker_defines.svh"
module ethernet_frame_rx_checker
    import efrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data,     // station_address
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fcs_ok, dest_match, too_short, frame_length[10:0], source_address[47:0],
    // ether_type[15:0], two zero bits
    output logic [79:0] m_axis_tdata
);

    logic [47:0] r_station;
    logic        r_in_valid;
    t_item       r_in;
    logic        r_out_valid;
    t_report     r_out;

    logic        advance;
    logic        fire;
    t_report     report;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

    efrc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_in),
        .i_station (r_station),
        .o_report  (report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station   <= STATION_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_station <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= fire && r_in.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.frame_byte <= s_axis_tdata;
            r_in.last_byte  <= s_axis_tlast;
        end
        if (fire && r_in.last_byte) begin
            r_out <= report;
        end
    end

    // A report only follows the final byte of a frame.
    `EFRC_ASSERT(a_report_after_last, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.last_byte),
        "report without final byte")
    // Short frames carry no check results or captures.
    `EFRC_ASSERT(a_short_clears, i_clk, i_rst_n,
        r_out_valid && r_out.too_short |-> !r_out.fcs_ok && !r_out.dest_match &&
        r_out.source_address == 48'd0 && r_out.ether_type == 16'd0,
        "short frame with results")
    // The short flag agrees with the reported length.
    `EFRC_ASSERT(a_short_length, i_clk, i_rst_n,
        r_out_valid |-> (r_out.too_short == (r_out.frame_length < MIN_FRAME)),
        "short flag and length disagree")
    // A held input byte is not dropped while the report stage stalls.
    `EFRC_ASSERT(a_input_held, i_clk, i_rst_n,
        r_in_valid && !advance |=> r_in_valid && $stable(r_in),
        "input stage lost a byte")

endmodule
